// ===== hdl/block_mean_estimator_defines.svh =====
// assertion macros for the block mean estimator
`ifndef BLOCK_MEAN_ESTIMATOR_DEFINES_SVH
`define BLOCK_MEAN_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BME_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("block mean estimator check failed");
`define BME_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("block mean estimator check failed");
`else
`define BME_ASSERT_IMP(name, ante, cons)
`define BME_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== hdl/bme_pkg.sv =====
// types and constants shared by the block mean estimator
`timescale 1ns / 1ps

package bme_pkg;

	localparam int MEMB_W     = 17;
	localparam int WEIGHT_W   = 32;
	localparam int NUMER_W    = 64;
	localparam int DENOM_W    = 40;
	localparam int MEAN_W     = 32;
	localparam int NODE_CNT_W = 9;
	localparam int CLS_CNT_W  = 5;
	localparam int CFG_ADDR_W = 2;
	localparam int NODE_EXT_W = 13;
	localparam int CLS_EXT_W  = 7;
	localparam int RESULT_LIMIT = 16;
	localparam int DIV_STEPS  = 32;
	localparam int DIV_CNT_W  = 6;

	localparam logic [MEMB_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [MEAN_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
	localparam logic [MEAN_W-1:0] MEAN_MIN = 32'h8000_0000;

	localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CLASS_COUNT = 2'd1;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_PAIR   = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAIR,
		ST_FIN_LOAD,
		ST_FIN_CHECK,
		ST_FIN_DIV,
		ST_FIN_PUT,
		ST_FIN_CLEAR
	} state_t;

endpackage

// ===== hdl/block_mean_estimator.sv =====
// Block mean estimator top level.
// Input channel (in_valid/in_ready) takes one item per transfer: func 0 loads a
// membership weight into the store in the transfer cycle; func 1 streams a pair
// weight, which runs every class in use through one pipelined multiply and
// accumulate (read, tau product, weight product, accumulate), one class per
// cycle; func 2 emits one mean per class on the output
// channel (out_valid/out_ready).
// Each mean goes through one shared restoring divider, one quotient bit a
// cycle; the divide is skipped when the denominator is zero or the mean
// saturates, and all accumulators are cleared after the last mean is put out.
// in_ready is low while a pair or a finish is being worked on.
// The output register holds a result until it is taken; a stalled receiver
// holds the finish sequence, while a finished result waiting does not stop the
// next item from being taken.
// Configuration writes (cfg_valid/cfg_ready, always ready) set node_count and
// class_count; the user must make them only while idle, unchecked by the block.
// Reset clears the accumulators and sets node_count to 256 and class_count to
// 16; the membership store is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`include "block_mean_estimator_defines.svh"

module block_mean_estimator #(
	parameter int MAX_NODES   = 256,
	parameter int MAX_CLASSES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           func,
	input  logic [7:0]                           node_a,
	input  logic [7:0]                           node_b,
	input  logic [3:0]                           class_sel,
	input  logic [bme_pkg::MEMB_W-1:0]           membership,
	input  logic signed [bme_pkg::WEIGHT_W-1:0]  weight,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [3:0]                           class_out,
	output logic signed [bme_pkg::MEAN_W-1:0]    mean,
	output logic                                 empty_res,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bme_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [bme_pkg::NODE_CNT_W-1:0]       cfg_data
);

	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CLS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int ADDR_W    = NODE_W + CLS_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CLS_LIM   = (MAX_CLASSES < bme_pkg::RESULT_LIMIT) ?
		MAX_CLASSES : bme_pkg::RESULT_LIMIT;
	localparam int ACC_W     = (CLS_LIM > 1) ? $clog2(CLS_LIM) : 1;

	localparam int NW = bme_pkg::NUMER_W;
	localparam int DW = bme_pkg::DENOM_W;
	localparam int MW = bme_pkg::MEMB_W;
	localparam int PROD_W = MW + 1 + bme_pkg::WEIGHT_W;
	localparam int TERM_W = PROD_W - 16;

	bme_pkg::state_t state_q, state_d;

	logic [bme_pkg::NODE_CNT_W-1:0] node_count_q;
	logic [bme_pkg::CLS_CNT_W-1:0]  class_count_q;
	logic [bme_pkg::CLS_CNT_W-1:0]  nc;

	logic in_fire, load_ok, pair_ok;
	logic [bme_pkg::NODE_EXT_W-1:0] na_ext, nb_ext, nn_ext;
	logic [bme_pkg::CLS_EXT_W-1:0]  cs_ext, iq_ext;
	logic [MW-1:0] memb_sat;

	logic [MW-1:0] member_mem [MEM_DEPTH];

	logic [NODE_W-1:0] node_a_q, node_b_q;
	logic signed [bme_pkg::WEIGHT_W-1:0] weight_q;
	logic [bme_pkg::CLS_CNT_W-1:0] iq_q;

	logic issue, pair_done, fin_load, fin_check, div_step, put_fire, acc_clear, put_ok;

	logic [MW-1:0] ta_s1, tb_s1;
	logic [ACC_W-1:0] cls_s1, cls_s2, cls_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic [MW-1:0] p_s2, p_s3;
	logic [2*MW-1:0] tau_prod;
	logic signed [PROD_W-1:0] mul_w, prod_s3;

	logic [NW-1:0] numer_acc_q [CLS_LIM];
	logic [DW-1:0] denom_acc_q [CLS_LIM];
	logic [NW-1:0] numer_cur, numer_next, numer_rd;
	logic [DW-1:0] denom_cur, denom_next;
	logic [TERM_W-1:0] term;
	logic [NW:0] numer_sum;
	logic [DW:0] denom_sum;

	logic [bme_pkg::CLS_CNT_W-1:0] fq_q;
	logic [NW-1:0] mag_q;
	logic [DW-1:0] den_q;
	logic neg_q, zero_q, ovf_q, zero_c, ovf_c, last_c;
	logic [DW:0] rem_q, div_t, div_sub;
	logic div_ge;
	logic [bme_pkg::MEAN_W-1:0] dvd_q, quo_q, mean_c;
	logic [bme_pkg::DIV_CNT_W-1:0] dcnt_q;

	logic out_valid_q, empty_q, last_q;
	logic [3:0] class_out_q;
	logic [bme_pkg::MEAN_W-1:0] mean_q;

	// configuration
	assign cfg_ready = 1'b1;
	assign nc = (class_count_q > bme_pkg::CLS_CNT_W'(CLS_LIM)) ?
		bme_pkg::CLS_CNT_W'(CLS_LIM) : class_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= 9'd256;
			class_count_q <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_addr)
				bme_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
				bme_pkg::REG_CLASS_COUNT: class_count_q <= cfg_data[bme_pkg::CLS_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input decode
	assign in_fire  = in_valid && in_ready;
	assign na_ext   = {5'd0, node_a};
	assign nb_ext   = {5'd0, node_b};
	assign nn_ext   = {4'd0, node_count_q};
	assign cs_ext   = {3'd0, class_sel};
	assign iq_ext   = {2'd0, iq_q};
	assign memb_sat = (membership > bme_pkg::ONE_Q16) ? bme_pkg::ONE_Q16 : membership;

	assign load_ok = (func == bme_pkg::FUNC_LOAD)
		&& (na_ext < bme_pkg::NODE_EXT_W'(MAX_NODES))
		&& (cs_ext < bme_pkg::CLS_EXT_W'(MAX_CLASSES));
	assign pair_ok = (func == bme_pkg::FUNC_PAIR) && (node_a != node_b)
		&& (na_ext < bme_pkg::NODE_EXT_W'(MAX_NODES))
		&& (nb_ext < bme_pkg::NODE_EXT_W'(MAX_NODES))
		&& (na_ext < nn_ext) && (nb_ext < nn_ext) && (nc != '0);

	// membership store
	always_ff @(posedge clk) begin
		if (in_fire && load_ok)
			member_mem[{na_ext[NODE_W-1:0], cs_ext[CLS_W-1:0]}] <= memb_sat;
		if (issue) begin
			ta_s1 <= member_mem[{node_a_q, iq_ext[CLS_W-1:0]}];
			tb_s1 <= member_mem[{node_b_q, iq_ext[CLS_W-1:0]}];
		end
	end

	// sequencer
	assign put_ok    = !out_valid_q || out_ready;
	assign pair_done = (iq_q == nc) && !vld_s1 && !vld_s2 && !vld_s3;
	assign zero_c    = (den_q == '0);
	assign ovf_c     = (mag_q >= {8'd0, den_q, 16'd0});
	assign last_c    = (fq_q == nc - 5'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bme_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (func)
						bme_pkg::FUNC_PAIR: if (pair_ok) state_d = bme_pkg::ST_PAIR;
						bme_pkg::FUNC_FINISH: state_d = (nc == '0) ?
							bme_pkg::ST_FIN_CLEAR : bme_pkg::ST_FIN_LOAD;
						default: ;
					endcase
				end
			end
			bme_pkg::ST_PAIR: if (pair_done) state_d = bme_pkg::ST_IDLE;
			bme_pkg::ST_FIN_LOAD: state_d = bme_pkg::ST_FIN_CHECK;
			bme_pkg::ST_FIN_CHECK: state_d = (zero_c || ovf_c) ?
				bme_pkg::ST_FIN_PUT : bme_pkg::ST_FIN_DIV;
			bme_pkg::ST_FIN_DIV: begin
				if (dcnt_q == bme_pkg::DIV_CNT_W'(bme_pkg::DIV_STEPS - 1))
					state_d = bme_pkg::ST_FIN_PUT;
			end
			bme_pkg::ST_FIN_PUT: begin
				if (put_ok)
					state_d = last_c ? bme_pkg::ST_FIN_CLEAR : bme_pkg::ST_FIN_LOAD;
			end
			bme_pkg::ST_FIN_CLEAR: state_d = bme_pkg::ST_IDLE;
			default: state_d = bme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		issue     = 1'b0;
		fin_load  = 1'b0;
		fin_check = 1'b0;
		div_step  = 1'b0;
		put_fire  = 1'b0;
		acc_clear = 1'b0;
		case (state_q)
			bme_pkg::ST_IDLE: in_ready = 1'b1;
			bme_pkg::ST_PAIR: issue = (iq_q < nc);
			bme_pkg::ST_FIN_LOAD: fin_load = 1'b1;
			bme_pkg::ST_FIN_CHECK: fin_check = 1'b1;
			bme_pkg::ST_FIN_DIV: div_step = 1'b1;
			bme_pkg::ST_FIN_PUT: put_fire = put_ok;
			bme_pkg::ST_FIN_CLEAR: acc_clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bme_pkg::ST_IDLE;
			iq_q    <= '0;
			fq_q    <= '0;
			dcnt_q  <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			if (in_fire)
				iq_q <= '0;
			else if (issue)
				iq_q <= iq_q + 5'd1;
			if (in_fire)
				fq_q <= '0;
			else if (put_fire)
				fq_q <= fq_q + 5'd1;
			if (fin_check)
				dcnt_q <= '0;
			else if (div_step)
				dcnt_q <= dcnt_q + 6'd1;
		end
	end

	// multiply and accumulate pipeline
	assign tau_prod = ta_s1 * tb_s1;
	assign mul_w    = $signed({1'b0, p_s2}) * weight_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			node_a_q <= na_ext[NODE_W-1:0];
			node_b_q <= nb_ext[NODE_W-1:0];
			weight_q <= weight;
		end
		cls_s1  <= iq_q[ACC_W-1:0];
		cls_s2  <= cls_s1;
		cls_s3  <= cls_s2;
		p_s2    <= tau_prod[MW+15:16];
		p_s3    <= p_s2;
		prod_s3 <= mul_w;
	end

	assign numer_cur = numer_acc_q[cls_s3];
	assign denom_cur = denom_acc_q[cls_s3];
	assign term      = prod_s3[PROD_W-1:16];
	assign numer_sum = {numer_cur[NW-1], numer_cur} + {{(NW + 1 - TERM_W){term[TERM_W-1]}}, term};
	assign numer_next = (numer_sum[NW] != numer_sum[NW-1]) ?
		(numer_sum[NW] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}}) :
		numer_sum[NW-1:0];
	assign denom_sum  = {1'b0, denom_cur} + {{(DW + 1 - MW){1'b0}}, p_s3};
	assign denom_next = denom_sum[DW] ? {DW{1'b1}} : denom_sum[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CLS_LIM; k++) begin
				numer_acc_q[k] <= '0;
				denom_acc_q[k] <= '0;
			end
		end else if (acc_clear) begin
			for (int k = 0; k < CLS_LIM; k++) begin
				numer_acc_q[k] <= '0;
				denom_acc_q[k] <= '0;
			end
		end else if (vld_s3) begin
			numer_acc_q[cls_s3] <= numer_next;
			denom_acc_q[cls_s3] <= denom_next;
		end
	end

	// finish: restoring divider, one quotient bit per cycle
	assign numer_rd = numer_acc_q[fq_q[ACC_W-1:0]];
	assign div_t    = {rem_q[DW-1:0], dvd_q[bme_pkg::MEAN_W-1]};
	assign div_ge   = (div_t >= {1'b0, den_q});
	assign div_sub  = div_t - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (fin_load) begin
			neg_q <= numer_rd[NW-1];
			mag_q <= numer_rd[NW-1] ? (~numer_rd + 64'd1) : numer_rd;
			den_q <= denom_acc_q[fq_q[ACC_W-1:0]];
		end
		if (fin_check) begin
			zero_q <= zero_c;
			ovf_q  <= ovf_c;
			rem_q  <= {1'b0, mag_q[DW+15:16]};
			dvd_q  <= {mag_q[15:0], 16'd0};
		end
		if (div_step) begin
			rem_q <= div_ge ? div_sub : div_t;
			dvd_q <= {dvd_q[bme_pkg::MEAN_W-2:0], 1'b0};
			quo_q <= {quo_q[bme_pkg::MEAN_W-2:0], div_ge};
		end
	end

	always_comb begin
		if (zero_q)
			mean_c = '0;
		else if (ovf_q)
			mean_c = neg_q ? bme_pkg::MEAN_MIN : bme_pkg::MEAN_MAX;
		else if (!neg_q)
			mean_c = quo_q[bme_pkg::MEAN_W-1] ? bme_pkg::MEAN_MAX : quo_q;
		else
			mean_c = (quo_q > bme_pkg::MEAN_MIN) ? bme_pkg::MEAN_MIN : (~quo_q + 32'd1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (put_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			class_out_q <= fq_q[3:0];
			mean_q      <= mean_c;
			empty_q     <= zero_q;
			last_q      <= last_c;
		end
	end

	assign out_valid = out_valid_q;
	assign class_out = class_out_q;
	assign mean      = mean_q;
	assign empty_res = empty_q;
	assign last      = last_q;

	`BME_ASSERT_IMP(a_pipe_in_pair, vld_s1 || vld_s2 || vld_s3, state_q == bme_pkg::ST_PAIR)
	`BME_ASSERT_NXT(a_last_clears, put_fire && last_c, state_q == bme_pkg::ST_FIN_CLEAR)
	`BME_ASSERT_IMP(a_empty_zero, out_valid_q && empty_q, mean_q == '0)
	`BME_ASSERT_IMP(a_rem_bound, state_q == bme_pkg::ST_FIN_DIV, rem_q < {1'b0, den_q})

endmodule
